[design/lpns_pkg.sv]
// Shared types and constants for the length-prefixed unit splitter.
package lpns_pkg;

    // Fixed field widths of the streams.
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned SIZE_W     = 3;
    localparam int unsigned LEN_W      = 32;
    localparam int unsigned CONSUMED_W = 24;
    localparam int unsigned S_TDATA_W  = 8;
    localparam int unsigned M_TDATA_W  = 40;
    localparam int unsigned M_TUSER_W  = 4;

    // Queue between the parser and the output stage.
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Prefix sizes with a defined length.
    localparam logic [SIZE_W-1:0] SIZE_ONE  = 3'd1;
    localparam logic [SIZE_W-1:0] SIZE_TWO  = 3'd2;
    localparam logic [SIZE_W-1:0] SIZE_FOUR = 3'd4;
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_FOUR;

    // Buffer status reported on the final byte.
    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_TRUNC_PREFIX  = 2'd1,
        ST_TRUNC_PAYLOAD = 2'd2
    } status_t;

    // One result record as it travels through the queue.
    typedef struct packed {
        logic [BYTE_W-1:0]     unit_byte;
        logic                  byte_valid;
        logic                  unit_start;
        logic                  unit_end;
        logic                  empty_unit;
        logic                  done_res;
        status_t               status;
        logic [CONSUMED_W-1:0] consumed_bytes;
    } result_t;

    // Queue control between the back stage and the queue.
    typedef struct packed {
        logic    empty;
        result_t head;
    } queue_head_t;

endpackage

[design/lpns_front.sv]
// Parser front end: accepts bytes, tracks prefix and payload state, builds result records.
module lpns_front #(
    parameter int unsigned COUNT_WIDTH = 24
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [lpns_pkg::SIZE_W-1:0]          cfg_wr_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [lpns_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic                                 s_tlast,
    input  logic                                 q_full,
    output logic                                 q_push,
    output lpns_pkg::result_t                    q_push_rec
);

    localparam logic [COUNT_WIDTH-1:0] TOTAL_MAX = {COUNT_WIDTH{1'b1}};

    logic [lpns_pkg::SIZE_W-1:0] length_field_bytes_reg;
    logic [lpns_pkg::SIZE_W-1:0] prefix_bytes_seen_reg, prefix_bytes_seen_next;
    logic [lpns_pkg::LEN_W-1:0]  length_accumulator_reg, length_accumulator_next;
    logic [lpns_pkg::LEN_W-1:0]  bytes_remaining_reg, bytes_remaining_next;
    logic                        in_payload_reg, in_payload_next;
    logic [COUNT_WIDTH-1:0]      byte_total_reg, byte_total_next;

    logic                        accept;
    logic                        emit;
    logic [lpns_pkg::SIZE_W-1:0] need;
    logic [lpns_pkg::LEN_W-1:0]  acc_shifted;
    logic [lpns_pkg::LEN_W-1:0]  announced_len;
    logic [lpns_pkg::SIZE_W-1:0] seen_inc;
    logic [31:0]                 total_wide;
    lpns_pkg::result_t           rec;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept && emit;
    assign q_push_rec = rec;

    // A size of zero still takes one prefix byte.
    assign need = (length_field_bytes_reg == '0) ? lpns_pkg::SIZE_W'(1) : length_field_bytes_reg;
    assign acc_shifted = {length_accumulator_reg[lpns_pkg::LEN_W-lpns_pkg::BYTE_W-1:0], s_tdata};
    assign seen_inc = prefix_bytes_seen_reg + lpns_pkg::SIZE_W'(1);

    // Only the prefix sizes one, two and four announce a length.
    always_comb begin
        unique case (length_field_bytes_reg)
            lpns_pkg::SIZE_ONE:  announced_len = {24'd0, acc_shifted[7:0]};
            lpns_pkg::SIZE_TWO:  announced_len = {16'd0, acc_shifted[15:0]};
            lpns_pkg::SIZE_FOUR: announced_len = acc_shifted;
            default:             announced_len = '0;
        endcase
    end

    // Next state and result record for the byte on the input.
    always_comb begin
        prefix_bytes_seen_next  = prefix_bytes_seen_reg;
        length_accumulator_next = length_accumulator_reg;
        bytes_remaining_next    = bytes_remaining_reg;
        in_payload_next         = in_payload_reg;
        emit                    = 1'b0;
        rec                     = '0;

        if (in_payload_reg) begin
            rec.unit_byte  = s_tdata;
            rec.byte_valid = 1'b1;
            rec.unit_start = (bytes_remaining_reg == length_accumulator_reg);
            bytes_remaining_next = bytes_remaining_reg - lpns_pkg::LEN_W'(1);
            if (bytes_remaining_reg == lpns_pkg::LEN_W'(1)) begin
                rec.unit_end            = 1'b1;
                in_payload_next         = 1'b0;
                length_accumulator_next = '0;
            end
            emit = 1'b1;
        end else begin
            length_accumulator_next = acc_shifted;
            prefix_bytes_seen_next  = seen_inc;
            if (seen_inc >= need) begin
                prefix_bytes_seen_next = '0;
                if (announced_len == '0) begin
                    rec.empty_unit          = 1'b1;
                    length_accumulator_next = '0;
                    emit                    = 1'b1;
                end else begin
                    in_payload_next         = 1'b1;
                    bytes_remaining_next    = announced_len;
                    length_accumulator_next = announced_len;
                end
            end
        end

        // Saturating byte count for the buffer.
        if (byte_total_reg != TOTAL_MAX) begin
            byte_total_next = byte_total_reg + COUNT_WIDTH'(1);
        end else begin
            byte_total_next = byte_total_reg;
        end
        total_wide = 32'(byte_total_next);

        // The final byte reports status and clears the buffer state.
        if (s_tlast) begin
            rec.done_res = 1'b1;
            if (in_payload_next) begin
                rec.status = lpns_pkg::ST_TRUNC_PAYLOAD;
            end else if (prefix_bytes_seen_next != '0) begin
                rec.status = lpns_pkg::ST_TRUNC_PREFIX;
            end else begin
                rec.status         = lpns_pkg::ST_OK;
                rec.consumed_bytes = total_wide[lpns_pkg::CONSUMED_W-1:0];
            end
            prefix_bytes_seen_next  = '0;
            length_accumulator_next = '0;
            bytes_remaining_next    = '0;
            in_payload_next         = 1'b0;
            byte_total_next         = '0;
            emit                    = 1'b1;
        end
    end

    // Configuration and parser state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_field_bytes_reg <= lpns_pkg::SIZE_RESET;
            prefix_bytes_seen_reg  <= '0;
            length_accumulator_reg <= '0;
            bytes_remaining_reg    <= '0;
            in_payload_reg         <= 1'b0;
            byte_total_reg         <= '0;
        end else begin
            if (cfg_wr_en) begin
                length_field_bytes_reg <= cfg_wr_data;
            end
            if (accept) begin
                prefix_bytes_seen_reg  <= prefix_bytes_seen_next;
                length_accumulator_reg <= length_accumulator_next;
                bytes_remaining_reg    <= bytes_remaining_next;
                in_payload_reg         <= in_payload_next;
                byte_total_reg         <= byte_total_next;
            end
        end
    end

    // Inside a payload there is always at least one byte to come.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_payload_reg |-> bytes_remaining_reg != '0)
        else $error("payload state with no bytes remaining");

    // No prefix bytes are pending while a payload runs.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_payload_reg |-> prefix_bytes_seen_reg == '0)
        else $error("prefix count nonzero inside a payload");

    // The final byte of a buffer leaves the parser cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> (!in_payload_reg && prefix_bytes_seen_reg == '0
                                 && byte_total_reg == '0))
        else $error("buffer state not cleared after the final byte");

endmodule

[design/lpns_queue.sv]
// Short register queue of result records between the parser and the output stage.
module lpns_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  lpns_pkg::result_t     push_rec,
    output logic                  full,
    input  logic                  pop,
    output lpns_pkg::queue_head_t head
);

    lpns_pkg::result_t                entries_reg [lpns_pkg::QUEUE_DEPTH];
    logic [lpns_pkg::QPTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [lpns_pkg::QCNT_W-1:0]      count_reg;
    logic                             do_push, do_pop;

    assign full       = (count_reg == lpns_pkg::QCNT_W'(lpns_pkg::QUEUE_DEPTH));
    assign head.empty = (count_reg == '0);
    assign head.head  = entries_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && !head.empty;

    // Entry storage carries payload only.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_rec;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + lpns_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + lpns_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + lpns_pkg::QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - lpns_pkg::QCNT_W'(1);
            end
        end
    end

    // A request offered to a full queue would be lost.
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into a full queue");

endmodule

[design/lpns_back.sv]
// Output stage: pops result records into the registered master stream.
module lpns_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lpns_pkg::queue_head_t               head,
    output logic                                pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lpns_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [lpns_pkg::M_TUSER_W-1:0]      m_tuser,
    output logic                                m_tlast
);

    localparam int unsigned PAD_W = lpns_pkg::M_TDATA_W - lpns_pkg::BYTE_W - 2
                                    - lpns_pkg::CONSUMED_W;

    logic              m_tvalid_reg;
    lpns_pkg::result_t out_rec_reg;

    // Load the output register when it is empty or being drained.
    assign pop = !head.empty && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (!m_tvalid_reg || m_tready) begin
            m_tvalid_reg <= !head.empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_rec_reg <= head.head;
        end
    end

    // Pack the record onto the stream fields.
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_rec_reg.consumed_bytes, out_rec_reg.status,
                       out_rec_reg.unit_byte};
    assign m_tuser  = {out_rec_reg.empty_unit, out_rec_reg.unit_end, out_rec_reg.unit_start,
                       out_rec_reg.byte_valid};
    assign m_tlast  = out_rec_reg.done_res;

endmodule

[design/length_prefixed_nalu_splitter.sv]
// Top level of the length-prefixed unit splitter.
//
//   Channel   Direction  Beat contents
//   s_        in         one buffer byte; tlast on the final byte
//   m_        out        payload byte or empty-unit mark; tlast carries status and total
//   cfg_      in         prefix size in bytes (1, 2 or 4)
//
// One byte is taken per cycle while s_tready is high; the parser's counters are registered.
// A result reaches m_ through the queue entry, written at the accepting edge, and the
// output register, loaded from the queue head when it is empty or being drained.
// Synchronous active-low reset sets the prefix size to four and clears all buffer state.
// A two-entry queue decouples the parser from m_tready; s_tready drops only when it is full.
module length_prefixed_nalu_splitter #(
    parameter int unsigned COUNT_WIDTH = 24
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [lpns_pkg::SIZE_W-1:0]        cfg_wr_data,   // length_field_bytes
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lpns_pkg::S_TDATA_W-1:0]     s_tdata,       // [7:0] data_byte
    input  logic                               s_tlast,       // last_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] unit_byte, [9:8] status, [33:10] consumed_bytes, [39:34] zero
    output logic [lpns_pkg::M_TDATA_W-1:0]     m_tdata,
    // [0] byte_valid, [1] unit_start, [2] unit_end, [3] empty_unit
    output logic [lpns_pkg::M_TUSER_W-1:0]     m_tuser,
    output logic                               m_tlast        // done_res
);

    logic                  q_full;
    logic                  q_push;
    logic                  q_pop;
    lpns_pkg::result_t     q_push_rec;
    lpns_pkg::queue_head_t q_head;

    // Parser front end.
    lpns_front #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_push_rec (q_push_rec)
    );

    // Result queue.
    lpns_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_rec(q_push_rec),
        .full    (q_full),
        .pop     (q_pop),
        .head    (q_head)
    );

    // Output stage.
    lpns_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (q_head),
        .pop     (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule
